### design/leib_pkg.sv
package leib_pkg;

  localparam logic [7:0] KEY_DUMP = 8'h10;
  localparam logic [7:0] KEY_KILL = 8'h15;
  localparam logic [7:0] KEY_BS   = 8'h08;
  localparam logic [7:0] KEY_DEL  = 8'h7F;
  localparam logic [7:0] KEY_EOF  = 8'h04;
  localparam logic [7:0] KEY_CR   = 8'h0D;
  localparam logic [7:0] KEY_LF   = 8'h0A;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] RD_BYTE      = 2'd0;
  localparam logic [1:0] RD_EMPTY     = 2'd1;
  localparam logic [1:0] RD_EOF       = 2'd2;
  localparam logic [1:0] RD_EOF_HELD  = 2'd3;

  typedef struct packed {
    logic       line_end;
    logic [7:0] read_byte;
    logic [1:0] read_status;
    logic       key_dropped;
    logic       dump_request;
    logic       line_ready;
    logic [7:0] erase_count;
    logic [7:0] echo_byte;
    logic       echo_valid;
  } result_t;

endpackage

### design/line_edit_input_buffer.sv
// A keystroke result is registered in the cycle after its transaction; a
// read result passes first through the line store's registered read port
// and then into the output register. One item is in work at a time: no new
// transaction is taken until the block is idle and its output is free or taken.
// Reset clears the read, commit and edit pointers and the output register;
// the line store is not cleared and needs no clearing pass.
module line_edit_input_buffer
  import leib_pkg::*;
#(
  parameter int BUF_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] key_code, [8] read_started, [15:9] zero
  input  logic [15:0] s_axis_tdata_i,
  // [0] cmd
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] echo_valid, [8:1] echo_byte, [16:9] erase_count, [17] line_ready,
  // [18] dump_request, [19] key_dropped, [21:20] read_status,
  // [29:22] read_byte, [31:30] zero
  output logic [31:0] m_axis_tdata_o,
  // line_end
  output logic        m_axis_tlast_o
);

  localparam int PW = $clog2(2 * BUF_DEPTH);
  localparam int SW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [PW-1:0] PTR_MAX = PW'(2 * BUF_DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P = PW'(BUF_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_MAX) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PTR_MAX : p - PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dist(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
    return (a >= b) ? a - b : a + (PTR_MAX - b) + PW'(1);
  endfunction

  function automatic logic [SW-1:0] slot(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return s[SW-1:0];
  endfunction

  logic [7:0]    line_store_q [BUF_DEPTH];
  logic [7:0]    rd_data_q;
  logic [PW-1:0] read_ptr_q, read_ptr_d;
  logic [PW-1:0] commit_ptr_q, commit_ptr_d;
  logic [PW-1:0] edit_ptr_q, edit_ptr_d;
  logic          state_q, state_d;
  logic          started_q, started_d;
  logic          out_valid_q, out_valid_d;
  result_t       out_q, out_d;

  logic          accept;
  logic [7:0]    key;
  logic [7:0]    ch;
  logic [PW-1:0] edit_inc;
  logic [PW-1:0] kill_dist;
  logic          wr_en;
  logic [SW-1:0] wr_addr;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign key             = s_axis_tdata_i[7:0];
  assign ch              = (key == KEY_CR) ? KEY_LF : key;
  assign edit_inc        = ptr_inc(edit_ptr_q);
  assign kill_dist       = ptr_dist(edit_ptr_q, commit_ptr_q);

  always_comb begin
    read_ptr_d   = read_ptr_q;
    commit_ptr_d = commit_ptr_q;
    edit_ptr_d   = edit_ptr_q;
    state_d      = state_q;
    started_d    = started_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_d        = out_q;
    wr_en        = 1'b0;
    wr_addr      = slot(edit_ptr_q);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d = '0;
          if (s_axis_tuser_i == CMD_READ) begin
            started_d = s_axis_tdata_i[8];
            state_d   = ST_READ;
          end else begin
            out_valid_d = 1'b1;
            if (key == KEY_DUMP) begin
              out_d.dump_request = 1'b1;
            end else if (key == KEY_KILL) begin
              out_d.erase_count = (kill_dist > PW'(255)) ? 8'hFF : 8'(kill_dist);
              edit_ptr_d = commit_ptr_q;
            end else if (key == KEY_BS || key == KEY_DEL) begin
              if (edit_ptr_q != commit_ptr_q) begin
                edit_ptr_d        = ptr_dec(edit_ptr_q);
                out_d.erase_count = 8'd1;
              end
            end else if (key != 8'h00) begin
              if (ptr_dist(edit_ptr_q, read_ptr_q) < DEPTH_P) begin
                wr_en            = 1'b1;
                edit_ptr_d       = edit_inc;
                out_d.echo_valid = 1'b1;
                out_d.echo_byte  = ch;
                if (ch == KEY_LF || ch == KEY_EOF ||
                    ptr_dist(edit_inc, read_ptr_q) == DEPTH_P) begin
                  commit_ptr_d     = edit_inc;
                  out_d.line_ready = 1'b1;
                end
              end else begin
                out_d.key_dropped = 1'b1;
              end
            end
          end
        end
      end
      ST_READ: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        if (read_ptr_q == commit_ptr_q) begin
          out_d.read_status = RD_EMPTY;
        end else if (rd_data_q == KEY_EOF) begin
          if (started_q) begin
            out_d.read_status = RD_EOF_HELD;
          end else begin
            read_ptr_d        = ptr_inc(read_ptr_q);
            out_d.read_status = RD_EOF;
          end
        end else begin
          read_ptr_d        = ptr_inc(read_ptr_q);
          out_d.read_status = RD_BYTE;
          out_d.read_byte   = rd_data_q;
          out_d.line_end    = (rd_data_q == KEY_LF);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_store_q[wr_addr] <= ch;
    end
    rd_data_q <= line_store_q[slot(read_ptr_q)];
    started_q <= started_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_ptr_q   <= '0;
      commit_ptr_q <= '0;
      edit_ptr_q   <= '0;
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      read_ptr_q   <= read_ptr_d;
      commit_ptr_q <= commit_ptr_d;
      edit_ptr_q   <= edit_ptr_d;
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_q.line_end;
  assign m_axis_tdata_o  = {2'b00, out_q.read_byte, out_q.read_status, out_q.key_dropped,
                            out_q.dump_request, out_q.line_ready, out_q.erase_count,
                            out_q.echo_byte, out_q.echo_valid};

endmodule

### bench/tb.sv
module tb
  import leib_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 128;
  localparam int PTR_MOD     = 2 * DEPTH;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = '0;
  logic        s_axis_tuser_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  line_edit_input_buffer #(
    .BUF_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  logic [7:0] line_mem [DEPTH];
  int         rd_ptr = 0;
  int         cm_ptr = 0;
  int         ed_ptr = 0;

  result_t    pending_results [$];
  int         err_cnt        = 0;
  int         cycle_cnt      = 0;
  int         sent_cnt       = 0;
  int         send_idle_pct  = 0;
  int         recv_idle_pct  = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int ring_dist(int a, int b);
    return (a + PTR_MOD - b) % PTR_MOD;
  endfunction

  function automatic result_t tty_step(logic cmd, logic [7:0] key, logic started);
    result_t    r;
    logic [7:0] c;
    int         n;
    r = '0;
    if (cmd == CMD_KEY) begin
      if (key == KEY_DUMP) begin
        r.dump_request = 1'b1;
      end else if (key == KEY_KILL) begin
        n = ring_dist(ed_ptr, cm_ptr);
        r.erase_count = (n > 255) ? 8'd255 : 8'(n);
        ed_ptr = cm_ptr;
      end else if (key == KEY_BS || key == KEY_DEL) begin
        if (ed_ptr != cm_ptr) begin
          ed_ptr = (ed_ptr + PTR_MOD - 1) % PTR_MOD;
          r.erase_count = 8'd1;
        end
      end else if (key != 8'h00) begin
        if (ring_dist(ed_ptr, rd_ptr) < DEPTH) begin
          c = (key == KEY_CR) ? KEY_LF : key;
          line_mem[ed_ptr % DEPTH] = c;
          ed_ptr = (ed_ptr + 1) % PTR_MOD;
          r.echo_valid = 1'b1;
          r.echo_byte  = c;
          if (c == KEY_LF || c == KEY_EOF || ring_dist(ed_ptr, rd_ptr) == DEPTH) begin
            cm_ptr = ed_ptr;
            r.line_ready = 1'b1;
          end
        end else begin
          r.key_dropped = 1'b1;
        end
      end
    end else begin
      if (rd_ptr == cm_ptr) begin
        r.read_status = RD_EMPTY;
      end else begin
        c = line_mem[rd_ptr % DEPTH];
        if (c == KEY_EOF) begin
          if (started) begin
            r.read_status = RD_EOF_HELD;
          end else begin
            rd_ptr = (rd_ptr + 1) % PTR_MOD;
            r.read_status = RD_EOF;
          end
        end else begin
          rd_ptr = (rd_ptr + 1) % PTR_MOD;
          r.read_status = RD_BYTE;
          r.read_byte   = c;
          r.line_end    = (c == KEY_LF);
        end
      end
    end
    return r;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pending_results.push_back(tty_step(s_axis_tuser_i, s_axis_tdata_i[7:0],
                                           s_axis_tdata_i[8]));
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tlast_o, m_axis_tdata_o[29:0]};
        if (pending_results.size() == 0) begin
          $error("result transaction with no expected result: tdata %h", m_axis_tdata_o);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          compare_field("echo_valid", want.echo_valid, got.echo_valid);
          compare_field("echo_byte", want.echo_byte, got.echo_byte);
          compare_field("erase_count", want.erase_count, got.erase_count);
          compare_field("line_ready", want.line_ready, got.line_ready);
          compare_field("dump_request", want.dump_request, got.dump_request);
          compare_field("key_dropped", want.key_dropped, got.key_dropped);
          compare_field("read_status", want.read_status, got.read_status);
          compare_field("read_byte", want.read_byte, got.read_byte);
          compare_field("line_end", want.line_end, got.line_end);
          compare_field("tdata_pad", 0, m_axis_tdata_o[31:30]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** line_edit_input_buffer: FAILED **");
      $finish;
    end
  end

  task automatic send_item(logic cmd, logic [7:0] key, logic started);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {7'b0, started, key};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_cnt++;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic test_directed();
    send_item(CMD_READ, 8'h00, 1'b0);
    send_item(CMD_KEY, 8'h00, 1'b0);
    send_item(CMD_KEY, KEY_BS, 1'b0);
    send_item(CMD_KEY, KEY_KILL, 1'b1);
    send_item(CMD_KEY, KEY_DUMP, 1'b0);
    send_item(CMD_KEY, 8'h61, 1'b0);
    send_item(CMD_KEY, 8'hFF, 1'b1);
    send_item(CMD_KEY, KEY_DEL, 1'b0);
    send_item(CMD_KEY, 8'h80, 1'b0);
    send_item(CMD_KEY, KEY_KILL, 1'b0);
    send_item(CMD_KEY, 8'h78, 1'b0);
    send_item(CMD_KEY, KEY_CR, 1'b0);
    send_item(CMD_READ, 8'hFF, 1'b0);
    send_item(CMD_READ, 8'h00, 1'b1);
    send_item(CMD_READ, 8'h00, 1'b1);
    send_item(CMD_KEY, KEY_EOF, 1'b0);
    send_item(CMD_READ, 8'h00, 1'b1);
    send_item(CMD_READ, 8'h00, 1'b0);
    send_item(CMD_KEY, 8'h7E, 1'b0);
    send_item(CMD_KEY, KEY_LF, 1'b0);
    send_item(CMD_READ, 8'h00, 1'b0);
    send_item(CMD_READ, 8'h00, 1'b1);
  endtask

  task automatic test_random_lines(int n_items);
    int         target;
    int         len;
    int         n_reads;
    logic [7:0] key;
    logic       started;
    target = sent_cnt + n_items;
    while (sent_cnt < target) begin
      if ($urandom_range(9) == 0) begin
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        len = $urandom_range(12);
        repeat (len) begin
          if ($urandom_range(99) < 15) begin
            case ($urandom_range(4))
              0: key = KEY_BS;
              1: key = KEY_DEL;
              2: key = KEY_KILL;
              3: key = KEY_DUMP;
              default: key = 8'h00;
            endcase
          end else begin
            key = 8'($urandom_range(255));
          end
          send_item(CMD_KEY, key, 1'($urandom_range(1)));
        end
        case ($urandom_range(2))
          0: key = KEY_CR;
          1: key = KEY_LF;
          default: key = KEY_EOF;
        endcase
        send_item(CMD_KEY, key, 1'($urandom_range(1)));
        n_reads = len + $urandom_range(3);
        started = 1'b0;
        repeat (n_reads) begin
          send_item(CMD_READ, 8'($urandom_range(255)), started);
          started = ($urandom_range(9) != 0);
        end
      end
    end
  endtask

  task automatic test_full_ring();
    repeat (DEPTH + 4) begin
      send_item(CMD_KEY, 8'($urandom_range(8'h7E, 8'h20)), 1'($urandom_range(1)));
    end
    send_item(CMD_KEY, KEY_DUMP, 1'b0);
    send_item(CMD_KEY, KEY_BS, 1'b1);
    send_item(CMD_KEY, KEY_KILL, 1'b0);
    send_item(CMD_KEY, KEY_CR, 1'b0);
    repeat (DEPTH + 2) begin
      send_item(CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    set_idling(26, 73);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_lines(130);
    test_full_ring();
    set_idling(73, 26);
    test_random_lines(130);
    test_full_ring();
    set_idling(0, 0);
    test_random_lines(170);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("** line_edit_input_buffer: PASSED **");
    end else begin
      $display("** line_edit_input_buffer: FAILED **");
    end
    $finish;
  end

endmodule
